FILE: rtl/core/slcan_pkg.sv
package slcan_pkg;

    localparam int          MAX_DATA_BYTES_DEF = 8;
    localparam int          TIME_W             = 64;
    localparam int          REM_W              = 10;
    localparam int          STAMP_W            = 16;
    // long division in base 2^16: the last quotient digit is the 16-bit stamp
    localparam int          CHUNK_W            = STAMP_W;
    localparam int          DIV_STEPS          = TIME_W / CHUNK_W;
    // each digit is a multiply step, then a remainder step
    localparam int          DIV_CNT_W          = $clog2(2 * DIV_STEPS);
    localparam int          PART_W             = REM_W + CHUNK_W;
    localparam int          RECIP_W            = 27;
    localparam int          RECIP_SHIFT        = 36;
    localparam int          PROD_W             = PART_W + RECIP_W;
    localparam int          DIGIT_CNT_W        = 4;
    localparam int          ADDR_W             = 3;

    localparam logic [31:0]      STD_ID_MAX = 32'h0000_07FF;
    localparam logic [31:0]      EXT_ID_MAX = 32'h1FFF_FFFF;
    localparam logic [REM_W-1:0] US_PER_MS  = REM_W'(1000);
    // ceil(2^36 / 1000); exact quotient for every partial dividend below 1000 * 2^16
    localparam logic [RECIP_W-1:0] US_PER_MS_RECIP = RECIP_W'(68_719_477);

    localparam logic [DIGIT_CNT_W-1:0] STD_ID_DIGITS = DIGIT_CNT_W'(3);
    localparam logic [DIGIT_CNT_W-1:0] EXT_ID_DIGITS = DIGIT_CNT_W'(8);
    localparam logic [DIGIT_CNT_W-1:0] STAMP_DIGITS  = DIGIT_CNT_W'(4);

    localparam logic [7:0] CHAR_STD  = 8'h74;   // 't'
    localparam logic [7:0] CHAR_EXT  = 8'h54;   // 'T'
    localparam logic [7:0] CHAR_ZERO = 8'h30;   // '0'
    localparam logic [7:0] CHAR_CR   = 8'h0D;

    // register index, taken from paddr[ADDR_W-1:2]
    localparam logic [ADDR_W-3:0] REG_TS_ENABLE = '0;

    typedef struct packed {
        logic [31:0]       frame_id;
        logic [7:0]        data_length;
        logic [7:0]        data_byte_0;
        logic [7:0]        data_byte_1;
        logic [7:0]        data_byte_2;
        logic [7:0]        data_byte_3;
        logic [7:0]        data_byte_4;
        logic [7:0]        data_byte_5;
        logic [7:0]        data_byte_6;
        logic [7:0]        data_byte_7;
        logic [TIME_W-1:0] time_us;
    } frame_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       line_end;
    } chr_t;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_DIV   = 8'b0000_0010,
        ST_HEAD  = 8'b0000_0100,
        ST_ID    = 8'b0000_1000,
        ST_DLC   = 8'b0001_0000,
        ST_DATA  = 8'b0010_0000,
        ST_STAMP = 8'b0100_0000,
        ST_CR    = 8'b1000_0000
    } state_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
        begin
            c = 8'h30 + {4'd0, nib};
        end
        else
        begin
            c = 8'h57 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/can_frame_to_slcan_ascii_core.sv
// CAN frame to SLCAN text line encoder.
// Input channel (frame_valid/frame_ready/frame): one CAN frame per beat. The
// block takes a frame only when idle; frame_ready stays low while a line is
// in progress. Output channel (chr_valid/chr_ready/chr): one ASCII character
// per beat, line_end set on the closing carriage return.
// A frame with an identifier above 0x1FFFFFFF is dropped in its accept cycle.
// With the timestamp enabled, a reciprocal multiplier shared by all digits
// divides time_us by 1000 as a base-2^16 long division of four digits, each
// a multiply step then a remainder step, before the first character.
// Characters then leave at one per cycle while the receiver takes them. A
// stalled receiver holds the output register and the sequencer waits with
// it; nothing is lost.
// Configuration: APB register 0 (byte address 0), bit 0 = timestamp enable.
// Reset clears the sequencer and output valid, and sets timestamp enable.
module can_frame_to_slcan_ascii_core #(
    parameter int MAX_DATA_BYTES = slcan_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          frame_valid,
    output logic                          frame_ready,
    input  slcan_pkg::frame_t             frame,
    output logic                          chr_valid,
    input  logic                          chr_ready,
    output slcan_pkg::chr_t               chr,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [slcan_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int LEN_W = $clog2(MAX_DATA_BYTES + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_DATA_BYTES);

    slcan_pkg::state_t state_reg, state_next;
    logic       ts_en_reg;
    logic       chr_valid_reg, chr_valid_next;
    slcan_pkg::chr_t chr_reg, chr_next;

    logic [31:0]                        id_reg, id_next;
    logic                               std_reg, std_next;
    logic [LEN_W-1:0]                   len_reg, len_next;
    logic                               nib_lo_reg, nib_lo_next;
    logic [63:0]                        data_reg, data_next;
    logic [slcan_pkg::TIME_W-1:0]       dvd_reg, dvd_next;
    logic [slcan_pkg::REM_W-1:0]        rem_reg, rem_next;
    logic [slcan_pkg::PROD_W-1:0]       prod_reg, prod_next;
    logic [slcan_pkg::STAMP_W-1:0]      q_reg, q_next;
    logic [slcan_pkg::DIV_CNT_W-1:0]    div_cnt_reg, div_cnt_next;
    logic [slcan_pkg::DIGIT_CNT_W-1:0]  cnt_reg, cnt_next;

    logic                               adv;
    logic                               cfg_wr;
    logic [slcan_pkg::PART_W-1:0]       part;
    logic [slcan_pkg::STAMP_W-1:0]      q_digit;
    logic [slcan_pkg::PART_W-1:0]       part_rem;
    logic                               frame_std;
    logic [LEN_W-1:0]                   len_sat;

    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite
                         && (paddr[slcan_pkg::ADDR_W-1:2] == slcan_pkg::REG_TS_ENABLE);
    assign prdata      = (paddr[slcan_pkg::ADDR_W-1:2] == slcan_pkg::REG_TS_ENABLE)
                         ? {31'd0, ts_en_reg} : 32'd0;

    assign frame_ready = (state_reg == slcan_pkg::ST_IDLE);
    assign chr_valid   = chr_valid_reg;
    assign chr         = chr_reg;
    assign adv         = !chr_valid_reg || chr_ready;

    assign frame_std   = (frame.frame_id <= slcan_pkg::STD_ID_MAX);
    assign len_sat     = (frame.data_length > 8'(MAX_DATA_BYTES))
                         ? LEN_MAX : frame.data_length[LEN_W-1:0];

    // partial dividend: running remainder with the next 16-bit digit of time_us
    assign part     = {rem_reg, dvd_reg[slcan_pkg::TIME_W-1 -: slcan_pkg::CHUNK_W]};
    assign q_digit  = prod_reg[slcan_pkg::RECIP_SHIFT +: slcan_pkg::STAMP_W];
    assign part_rem = part - (slcan_pkg::PART_W'(q_digit)
                              * slcan_pkg::PART_W'(slcan_pkg::US_PER_MS));

    always_comb
    begin
        state_next     = state_reg;
        chr_valid_next = chr_valid_reg;
        chr_next       = chr_reg;
        id_next        = id_reg;
        std_next       = std_reg;
        len_next       = len_reg;
        nib_lo_next    = nib_lo_reg;
        data_next      = data_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        prod_next      = prod_reg;
        q_next         = q_reg;
        div_cnt_next   = div_cnt_reg;
        cnt_next       = cnt_reg;

        if (chr_ready)
        begin
            chr_valid_next = 1'b0;
        end

        unique case (state_reg)
            slcan_pkg::ST_IDLE:
            begin
                if (frame_valid)
                begin
                    std_next     = frame_std;
                    id_next      = frame_std ? {frame.frame_id[11:0], 20'd0} : frame.frame_id;
                    len_next     = len_sat;
                    data_next    = {frame.data_byte_0, frame.data_byte_1,
                                    frame.data_byte_2, frame.data_byte_3,
                                    frame.data_byte_4, frame.data_byte_5,
                                    frame.data_byte_6, frame.data_byte_7};
                    dvd_next     = frame.time_us;
                    rem_next     = '0;
                    q_next       = '0;
                    div_cnt_next = '0;
                    // drop frames with an out-of-range identifier
                    if (frame.frame_id <= slcan_pkg::EXT_ID_MAX)
                    begin
                        state_next = ts_en_reg ? slcan_pkg::ST_DIV : slcan_pkg::ST_HEAD;
                    end
                end
            end
            slcan_pkg::ST_DIV:
            begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (!div_cnt_reg[0])
                begin
                    prod_next = slcan_pkg::PROD_W'(part)
                                * slcan_pkg::PROD_W'(slcan_pkg::US_PER_MS_RECIP);
                end
                else
                begin
                    // keep the digit, carry the remainder, advance to the next digit
                    rem_next = part_rem[slcan_pkg::REM_W-1:0];
                    q_next   = q_digit;
                    dvd_next = {dvd_reg[slcan_pkg::TIME_W-slcan_pkg::CHUNK_W-1:0],
                                {slcan_pkg::CHUNK_W{1'b0}}};
                end
                if (&div_cnt_reg)
                begin
                    state_next = slcan_pkg::ST_HEAD;
                end
            end
            slcan_pkg::ST_HEAD:
            begin
                if (adv)
                begin
                    chr_valid_next = 1'b1;
                    chr_next       = '{char_code: std_reg ? slcan_pkg::CHAR_STD
                                                          : slcan_pkg::CHAR_EXT,
                                       line_end: 1'b0};
                    cnt_next       = std_reg ? slcan_pkg::STD_ID_DIGITS
                                             : slcan_pkg::EXT_ID_DIGITS;
                    state_next     = slcan_pkg::ST_ID;
                end
            end
            slcan_pkg::ST_ID:
            begin
                if (adv)
                begin
                    chr_valid_next = 1'b1;
                    chr_next       = '{char_code: slcan_pkg::hex_char(id_reg[31:28]),
                                       line_end: 1'b0};
                    id_next        = {id_reg[27:0], 4'd0};
                    cnt_next       = cnt_reg - 1'b1;
                    if (cnt_reg == slcan_pkg::DIGIT_CNT_W'(1))
                    begin
                        state_next = slcan_pkg::ST_DLC;
                    end
                end
            end
            slcan_pkg::ST_DLC:
            begin
                if (adv)
                begin
                    chr_valid_next = 1'b1;
                    chr_next       = '{char_code: slcan_pkg::CHAR_ZERO + 8'(len_reg),
                                       line_end: 1'b0};
                    nib_lo_next    = 1'b0;
                    cnt_next       = slcan_pkg::STAMP_DIGITS;
                    if (len_reg != '0)
                    begin
                        state_next = slcan_pkg::ST_DATA;
                    end
                    else
                    begin
                        state_next = ts_en_reg ? slcan_pkg::ST_STAMP : slcan_pkg::ST_CR;
                    end
                end
            end
            slcan_pkg::ST_DATA:
            begin
                if (adv)
                begin
                    chr_valid_next = 1'b1;
                    chr_next       = '{char_code: slcan_pkg::hex_char(data_reg[63:60]),
                                       line_end: 1'b0};
                    data_next      = {data_reg[59:0], 4'd0};
                    nib_lo_next    = !nib_lo_reg;
                    if (nib_lo_reg)
                    begin
                        len_next = len_reg - 1'b1;
                        if (len_reg == LEN_W'(1))
                        begin
                            state_next = ts_en_reg ? slcan_pkg::ST_STAMP : slcan_pkg::ST_CR;
                        end
                    end
                end
            end
            slcan_pkg::ST_STAMP:
            begin
                if (adv)
                begin
                    chr_valid_next = 1'b1;
                    chr_next       = '{char_code: slcan_pkg::hex_char(
                                                      q_reg[slcan_pkg::STAMP_W-1 -: 4]),
                                       line_end: 1'b0};
                    q_next         = {q_reg[slcan_pkg::STAMP_W-5:0], 4'd0};
                    cnt_next       = cnt_reg - 1'b1;
                    if (cnt_reg == slcan_pkg::DIGIT_CNT_W'(1))
                    begin
                        state_next = slcan_pkg::ST_CR;
                    end
                end
            end
            slcan_pkg::ST_CR:
            begin
                if (adv)
                begin
                    chr_valid_next = 1'b1;
                    chr_next       = '{char_code: slcan_pkg::CHAR_CR, line_end: 1'b1};
                    state_next     = slcan_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = slcan_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slcan_pkg::ST_IDLE;
            chr_valid_reg <= 1'b0;
            ts_en_reg     <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            chr_valid_reg <= chr_valid_next;
            if (cfg_wr)
            begin
                ts_en_reg <= pwdata[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chr_reg     <= chr_next;
        id_reg      <= id_next;
        std_reg     <= std_next;
        len_reg     <= len_next;
        nib_lo_reg  <= nib_lo_next;
        data_reg    <= data_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        prod_reg    <= prod_next;
        q_reg       <= q_next;
        div_cnt_reg <= div_cnt_next;
        cnt_reg     <= cnt_next;
    end

endmodule
